/* rtl/tspc_pkg.sv */
// ============================================================================
// tspc_pkg - shared types and constants of the tile and sprite compositor
// Operation codes, store geometry, the sequencer status struct and the
// helpers that address the pattern sheet and pick a pixel nibble.
// ============================================================================
`default_nettype none

package tspc_pkg;

    // Operation codes carried in tuser
    localparam logic [2:0] OP_WRITE_SHEET   = 3'd0;
    localparam logic [2:0] OP_WRITE_NAME    = 3'd1;
    localparam logic [2:0] OP_WRITE_PALETTE = 3'd2;
    localparam logic [2:0] OP_WRITE_SPRITE  = 3'd3;
    localparam logic [2:0] OP_RENDER        = 3'd4;

    // Field widths
    localparam int OP_W     = 3;
    localparam int ADDR_W   = 13;
    localparam int DATA_W   = 24;
    localparam int COORD_W  = 8;
    localparam int COLOR_W  = 8;

    // Store geometry
    localparam int SHEET_DEPTH    = 8192;
    localparam int SHEET_AW       = 13;
    localparam int NAME_COLS      = 32;
    localparam int PALETTE_DEPTH  = 16;
    localparam int PALETTE_AW     = 4;
    localparam int SPRITE_WORD_W  = 24;

    // Parameter defaults
    localparam int SPRITE_COUNT_DEF = 64;
    localparam int SCREEN_ROWS_DEF  = 224;

    // Memory requests and status from the sequencer
    typedef struct packed {
        logic                  name_rd_en;
        logic                  spr_rd_en;
        logic                  pat_rd_en;
        logic [SHEET_AW-1:0]   pat_rd_addr;
        logic                  pal_rd_en;
        logic [PALETTE_AW-1:0] pal_rd_addr;
        logic                  pal_done;
    } ctl_req_t;

    // Sheet byte address of pixel (col,row) of a tile
    function automatic logic [SHEET_AW-1:0] pat_addr(
        input logic [7:0] tile,
        input logic [2:0] col,
        input logic [2:0] row
    );
        pat_addr = {tile[7:5], row, tile[4:0], col[2:1]};
    endfunction

    // Pick the nibble of a sheet byte: high nibble is the even column
    function automatic logic [3:0] pick_nibble(
        input logic [7:0] byte_val,
        input logic       odd
    );
        pick_nibble = odd ? byte_val[3:0] : byte_val[7:4];
    endfunction

endpackage

`default_nettype wire

/* rtl/tspc_ram.sv */
// ============================================================================
// tspc_ram - generic single-write, single-read synchronous RAM
// One write port and one read port with a registered read that holds its
// data while the read enable is low.
// ============================================================================
`default_nettype none

module tspc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

/* rtl/tspc_ctrl.sv */
// ============================================================================
// tspc_ctrl - render sequencer and pixel pipeline
// Reads the name entry; for a pixel on screen it then reads the background
// pattern and scans the sprite table one entry a cycle with a pattern read per sprite; then it reads the palette.
// ============================================================================
`default_nettype none

module tspc_ctrl #(
    parameter int SPRITE_COUNT = tspc_pkg::SPRITE_COUNT_DEF,
    parameter int SCREEN_ROWS  = tspc_pkg::SCREEN_ROWS_DEF,
    parameter int NAME_AW      = 10,
    parameter int SPR_AW       = 6
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             in_valid,
    input  wire logic [tspc_pkg::OP_W-1:0]        operation,
    input  wire logic [tspc_pkg::COORD_W-1:0]     pixel_x,
    input  wire logic [tspc_pkg::COORD_W-1:0]     pixel_y,
    input  wire logic                             out_free,
    output logic                                  in_ready,
    output logic      [NAME_AW-1:0]               name_rd_addr,
    output logic      [SPR_AW-1:0]                spr_rd_addr,
    input  wire logic [7:0]                       name_rd_data,
    input  wire logic [tspc_pkg::SPRITE_WORD_W-1:0] spr_rd_data,
    input  wire logic [7:0]                       pat_rd_data,
    output tspc_pkg::ctl_req_t                    ctl
);

    localparam int BG_TILE_ROWS = SCREEN_ROWS / 8;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_NAME  = 3'd1;
    localparam logic [2:0] ST_SPR   = 3'd2;
    localparam logic [2:0] ST_DRAIN = 3'd3;
    localparam logic [2:0] ST_PAL   = 3'd4;

    logic [2:0]        state_reg, state_next;
    logic [SPR_AW-1:0] idx_reg, idx_next;
    logic [7:0]        px_reg, px_next;
    logic [7:0]        py_reg, py_next;
    logic              bg_en_reg, bg_en_next;
    logic [3:0]        colour_reg, colour_next;
    logic              pend_valid_reg, pend_valid_next;
    logic              pend_hit_reg, pend_hit_next;
    logic              pend_odd_reg, pend_odd_next;

    logic       accept_render;
    logic       in_screen;
    logic       bg_rows_ok;
    logic [3:0] nib;
    logic [7:0] dx;
    logic [7:0] dy;
    logic       idx_last;

    assign in_ready      = (state_reg == ST_IDLE);
    assign accept_render = in_valid && in_ready && (operation == tspc_pkg::OP_RENDER);
    assign in_screen     = ({1'b0, pixel_y} < 9'(SCREEN_ROWS));
    assign bg_rows_ok    = ({4'b0, pixel_y[7:3]} < 9'(BG_TILE_ROWS));
    assign nib           = tspc_pkg::pick_nibble(pat_rd_data, pend_odd_reg);
    assign dx            = px_reg - spr_rd_data[7:0];
    assign dy            = py_reg - spr_rd_data[15:8];
    assign idx_last      = (idx_reg == SPR_AW'(SPRITE_COUNT - 1));

    // Name entry under the pixel: row-major, 32 columns
    assign name_rd_addr = NAME_AW'({pixel_y[7:3], pixel_x[7:3]});

    // Sequencer and pixel pipeline
    always_comb begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        px_next         = px_reg;
        py_next         = py_reg;
        bg_en_next      = bg_en_reg;
        pend_valid_next = 1'b0;
        pend_hit_next   = 1'b0;
        pend_odd_next   = 1'b0;
        colour_next     = colour_reg;
        spr_rd_addr     = '0;
        ctl             = '0;

        // Apply the pattern pixel that arrives this cycle; the last opaque hit wins
        if (pend_valid_reg && pend_hit_reg && (nib != 4'd0)) begin
            colour_next = nib;
        end

        case (state_reg)
            ST_IDLE: begin
                if (accept_render) begin
                    px_next         = pixel_x;
                    py_next         = pixel_y;
                    bg_en_next      = bg_rows_ok;
                    colour_next     = 4'd0;
                    ctl.name_rd_en  = 1'b1;
                    state_next      = in_screen ? ST_NAME : ST_DRAIN;
                end
            end
            ST_NAME: begin
                // Background pattern read, first sprite read
                ctl.pat_rd_en   = 1'b1;
                ctl.pat_rd_addr = tspc_pkg::pat_addr(name_rd_data, px_reg[2:0], py_reg[2:0]);
                pend_valid_next = 1'b1;
                pend_hit_next   = bg_en_reg;
                pend_odd_next   = px_reg[0];
                ctl.spr_rd_en   = 1'b1;
                spr_rd_addr     = '0;
                idx_next        = '0;
                state_next      = ST_SPR;
            end
            ST_SPR: begin
                // Test sprite idx_reg, read its pattern, fetch the next sprite
                ctl.pat_rd_en   = 1'b1;
                ctl.pat_rd_addr = tspc_pkg::pat_addr(spr_rd_data[23:16], dx[2:0], dy[2:0]);
                pend_valid_next = 1'b1;
                pend_hit_next   = (dx[7:3] == 5'd0) && (dy[7:3] == 5'd0);
                pend_odd_next   = dx[0];
                ctl.spr_rd_en   = !idx_last;
                spr_rd_addr     = idx_reg + SPR_AW'(1);
                idx_next        = idx_reg + SPR_AW'(1);
                if (idx_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                // Last pixel is applied now; read the palette
                ctl.pal_rd_en   = 1'b1;
                ctl.pal_rd_addr = colour_next;
                state_next      = ST_PAL;
            end
            ST_PAL: begin
                // Hold until the output register is free
                if (out_free) begin
                    ctl.pal_done = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            pend_valid_reg <= 1'b0;
        end else begin
            state_reg      <= state_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    // Payload state
    always_ff @(posedge aclk) begin
        idx_reg      <= idx_next;
        px_reg       <= px_next;
        py_reg       <= py_next;
        bg_en_reg    <= bg_en_next;
        colour_reg   <= colour_next;
        pend_hit_reg <= pend_hit_next;
        pend_odd_reg <= pend_odd_next;
    end

endmodule

`default_nettype wire

/* rtl/tile_sprite_pixel_compositor_top.sv */
// ============================================================================
// tile_sprite_pixel_compositor_top - tile and sprite pixel compositor
// Write requests load the pattern sheet, name table, palette and sprite
// table; a render request returns the composed RGB colour of one pixel.
// ============================================================================
// Write requests give no result.
// A render on screen is paced by the sprite scan: one sprite memory read and
// one pattern read per sprite. A render below the screen skips the scan. The
// input is not ready for a new request until the result is loaded into the
// output register, which waits while an earlier result is still held.
// aresetn clears the control state only; the stores are undefined until written.
`default_nettype none

module tile_sprite_pixel_compositor_top #(
    parameter int SPRITE_COUNT = tspc_pkg::SPRITE_COUNT_DEF,
    parameter int SCREEN_ROWS  = tspc_pkg::SCREEN_ROWS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // address[12:0], data[36:13], pixel_x[44:37], pixel_y[52:45], zero[55:53]
    input  wire logic [55:0] s_axis_tdata,
    // operation[2:0]
    input  wire logic [2:0]  s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // red[7:0], green[15:8], blue[23:16]
    output logic      [23:0] m_axis_tdata
);

    localparam int NAME_DEPTH = tspc_pkg::NAME_COLS * ((SCREEN_ROWS + 7) / 8);
    localparam int NAME_AW    = $clog2(NAME_DEPTH);
    localparam int SPR_AW     = (SPRITE_COUNT > 1) ? $clog2(SPRITE_COUNT) : 1;

    logic [tspc_pkg::OP_W-1:0]    operation;
    logic [tspc_pkg::ADDR_W-1:0]  address;
    logic [tspc_pkg::DATA_W-1:0]  data;
    logic [tspc_pkg::COORD_W-1:0] pixel_x;
    logic [tspc_pkg::COORD_W-1:0] pixel_y;

    assign operation = s_axis_tuser;
    assign address   = s_axis_tdata[12:0];
    assign data      = s_axis_tdata[36:13];
    assign pixel_x   = s_axis_tdata[44:37];
    assign pixel_y   = s_axis_tdata[52:45];

    logic in_accept;
    logic wr_sheet, wr_name, wr_pal, wr_spr;
    logic out_free;

    logic [NAME_AW-1:0] name_rd_addr;
    logic [SPR_AW-1:0]  spr_rd_addr;
    logic [7:0]         name_rd_data;
    logic [7:0]         pat_rd_data;
    logic [23:0]        spr_rd_data;
    logic [23:0]        pal_rd_data;
    tspc_pkg::ctl_req_t ctl;

    logic        m_valid_reg, m_valid_next;
    logic [23:0] m_data_reg, m_data_next;

    assign in_accept = s_axis_tvalid && s_axis_tready;
    assign out_free  = !m_valid_reg || m_axis_tready;

    // Decode write requests; drop addresses past the store
    assign wr_sheet = in_accept && (operation == tspc_pkg::OP_WRITE_SHEET);
    assign wr_name  = in_accept && (operation == tspc_pkg::OP_WRITE_NAME)
                      && ({1'b0, address} < 14'(NAME_DEPTH));
    assign wr_pal   = in_accept && (operation == tspc_pkg::OP_WRITE_PALETTE)
                      && (address[12:4] == 9'd0);
    assign wr_spr   = in_accept && (operation == tspc_pkg::OP_WRITE_SPRITE)
                      && ({1'b0, address} < 14'(SPRITE_COUNT));

    tspc_ctrl #(
        .SPRITE_COUNT (SPRITE_COUNT),
        .SCREEN_ROWS  (SCREEN_ROWS),
        .NAME_AW      (NAME_AW),
        .SPR_AW       (SPR_AW)
    ) u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (s_axis_tvalid),
        .operation    (operation),
        .pixel_x      (pixel_x),
        .pixel_y      (pixel_y),
        .out_free     (out_free),
        .in_ready     (s_axis_tready),
        .name_rd_addr (name_rd_addr),
        .spr_rd_addr  (spr_rd_addr),
        .name_rd_data (name_rd_data),
        .spr_rd_data  (spr_rd_data),
        .pat_rd_data  (pat_rd_data),
        .ctl          (ctl)
    );

    tspc_ram #(
        .WIDTH (8),
        .DEPTH (tspc_pkg::SHEET_DEPTH)
    ) u_pattern_ram (
        .aclk    (aclk),
        .wr_en   (wr_sheet),
        .wr_addr (address),
        .wr_data (data[7:0]),
        .rd_en   (ctl.pat_rd_en),
        .rd_addr (ctl.pat_rd_addr),
        .rd_data (pat_rd_data)
    );

    tspc_ram #(
        .WIDTH (8),
        .DEPTH (NAME_DEPTH)
    ) u_name_ram (
        .aclk    (aclk),
        .wr_en   (wr_name),
        .wr_addr (address[NAME_AW-1:0]),
        .wr_data (data[7:0]),
        .rd_en   (ctl.name_rd_en),
        .rd_addr (name_rd_addr),
        .rd_data (name_rd_data)
    );

    tspc_ram #(
        .WIDTH (24),
        .DEPTH (tspc_pkg::PALETTE_DEPTH)
    ) u_palette_ram (
        .aclk    (aclk),
        .wr_en   (wr_pal),
        .wr_addr (address[tspc_pkg::PALETTE_AW-1:0]),
        .wr_data (data),
        .rd_en   (ctl.pal_rd_en),
        .rd_addr (ctl.pal_rd_addr),
        .rd_data (pal_rd_data)
    );

    tspc_ram #(
        .WIDTH (tspc_pkg::SPRITE_WORD_W),
        .DEPTH (SPRITE_COUNT),
        .AW    (SPR_AW)
    ) u_sprite_ram (
        .aclk    (aclk),
        .wr_en   (wr_spr),
        .wr_addr (address[SPR_AW-1:0]),
        .wr_data (data),
        .rd_en   (ctl.spr_rd_en),
        .rd_addr (spr_rd_addr),
        .rd_data (spr_rd_data)
    );

    // Output register: load the palette colour, hold until taken
    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (m_valid_reg && m_axis_tready) begin
            m_valid_next = 1'b0;
        end
        if (ctl.pal_done) begin
            m_valid_next = 1'b1;
            m_data_next  = {pal_rd_data[7:0], pal_rd_data[15:8], pal_rd_data[23:16]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    // A result is loaded only into a free output register
    a_done_free: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.pal_done |-> out_free)
        else $error("result loaded over a pending result");

    // A render request blocks the input on the next cycle
    a_render_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_accept && (operation == tspc_pkg::OP_RENDER)) |=> !s_axis_tready)
        else $error("input accepted during a render");

    // A write request never produces a result
    a_write_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_accept && (operation != tspc_pkg::OP_RENDER)) |=> !ctl.pal_done)
        else $error("result after a write request");

    // The output valid rises only after a palette load
    a_valid_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(ctl.pal_done))
        else $error("output valid without a palette load");

endmodule

`default_nettype wire

/* tb/sv/tb_tile_sprite_pixel_compositor_top.sv */
// ============================================================================
// tb_tile_sprite_pixel_compositor_top - testbench of the pixel compositor
// Preloads a small tile set, the name entries of the screen rows that renders
// visit, the palette and the sprite table, then runs directed corner cases,
// an output stall and randomized traffic. A local predictor mirrors the
// stores and works out the colour of each render request. A monitor compares
// each colour it receives, field by field, with the oldest expected colour.
// ============================================================================
module tb_tile_sprite_pixel_compositor_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SPRITES       = tspc_pkg::SPRITE_COUNT_DEF;
    localparam int SCREEN_ROWS   = tspc_pkg::SCREEN_ROWS_DEF;
    localparam int NAME_COLS     = tspc_pkg::NAME_COLS;
    localparam int NAME_DEPTH    = NAME_COLS * ((SCREEN_ROWS + 7) / 8);
    localparam int BG_TILE_ROWS  = SCREEN_ROWS / 8;
    localparam int SHEET_DEPTH   = tspc_pkg::SHEET_DEPTH;
    localparam int PALETTE_DEPTH = tspc_pkg::PALETTE_DEPTH;
    localparam int TAIL_CYCLES   = 2 * SPRITES + 40;

    // Tiles 0x20..0x27 are the only ones that name entries and sprites use
    localparam logic [7:0] TILE_BASE    = 8'h20;
    localparam int         LOADED_TILES = 8;

    // Top band of the screen whose name entries are loaded (bottom row too)
    localparam int LOADED_TILE_ROWS = 8;
    localparam int LOADED_ROWS      = LOADED_TILE_ROWS * 8;
    localparam int SPRITE_Y_MIN     = 16;
    localparam int SPRITE_Y_MAX     = LOADED_ROWS - 16;

    // Codes the block treats as no-ops
    localparam logic [2:0] OP_RESERVED_LO  = 3'd5;
    localparam logic [2:0] OP_RESERVED_MID = 3'd6;
    localparam logic [2:0] OP_RESERVED_HI  = 3'd7;

    // red in the low byte, as on m_axis_tdata
    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } pixel_rgb_t;

    logic        aclk          = 1'b0;
    logic        aresetn       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata  = '0;
    logic [2:0]  s_axis_tuser  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;

    // Mirror of the block's stores
    logic [7:0]  sheet_mirror   [SHEET_DEPTH];
    logic [7:0]  name_mirror    [NAME_DEPTH];
    logic [23:0] palette_mirror [PALETTE_DEPTH];
    logic [23:0] sprite_mirror  [SPRITES];

    pixel_rgb_t  expected_colors [$];
    int          error_count   = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          hold_cycles   = 0;

    tile_sprite_pixel_compositor_top u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    // 4-bit pixel (col,row) of a tile; high nibble is the even column
    function automatic logic [3:0] tile_nibble(input logic [7:0] tile,
                                               input logic [2:0] col,
                                               input logic [2:0] row);
        int         sx;
        int         sy;
        logic [7:0] sheet_byte;
        sx = int'(tile[4:0]) * 8 + int'(col);
        sy = int'(tile[7:5]) * 8 + int'(row);
        sheet_byte = sheet_mirror[(sy * 128 + sx / 2) % SHEET_DEPTH];
        return (sx % 2 == 1) ? sheet_byte[3:0] : sheet_byte[7:4];
    endfunction

    // Palette index of the composed pixel: last opaque sprite, else background
    function automatic logic [3:0] compose_index(input logic [7:0] px,
                                                 input logic [7:0] py);
        logic [3:0]  idx;
        logic [3:0]  nib;
        logic [7:0]  dx;
        logic [7:0]  dy;
        logic [23:0] spr;
        int          i;
        idx = 4'd0;
        if (int'(py) >= SCREEN_ROWS) return 4'd0;
        if (int'(py[7:3]) < BG_TILE_ROWS)
            idx = tile_nibble(name_mirror[int'(py[7:3]) * NAME_COLS + int'(px[7:3])],
                              px[2:0], py[2:0]);
        for (i = 0; i < SPRITES; i++) begin
            spr = sprite_mirror[i];
            dx  = px - spr[7:0];
            dy  = py - spr[15:8];
            if (dx < 8 && dy < 8) begin
                nib = tile_nibble(spr[23:16], dx[2:0], dy[2:0]);
                if (nib != 4'd0) idx = nib;
            end
        end
        return idx;
    endfunction

    // Pick one tile of the loaded set
    function automatic logic [7:0] loaded_tile();
        return 8'(TILE_BASE + 8'($urandom_range(0, LOADED_TILES - 1)));
    endfunction

    // Rows with loaded name entries, or rows below the screen
    function automatic bit row_loaded(input logic [7:0] py);
        return (int'(py[7:3]) < LOADED_TILE_ROWS) || (int'(py[7:3]) == BG_TILE_ROWS - 1)
               || (int'(py) >= SCREEN_ROWS);
    endfunction

    // Update the mirror for an accepted request; queue the colour of a render
    function automatic void apply_request(input logic [2:0] op, input logic [12:0] addr,
                                          input logic [23:0] data, input logic [7:0] px,
                                          input logic [7:0] py);
        logic [23:0] c;
        pixel_rgb_t  rgb;
        case (op)
            tspc_pkg::OP_WRITE_SHEET: begin
                sheet_mirror[addr] = data[7:0];
            end
            tspc_pkg::OP_WRITE_NAME: begin
                if (addr < NAME_DEPTH) name_mirror[addr] = data[7:0];
            end
            tspc_pkg::OP_WRITE_PALETTE: begin
                if (addr < PALETTE_DEPTH) palette_mirror[addr] = data;
            end
            tspc_pkg::OP_WRITE_SPRITE: begin
                if (addr < SPRITES) sprite_mirror[addr] = data;
            end
            tspc_pkg::OP_RENDER: begin
                c = palette_mirror[compose_index(px, py)];
                rgb.red   = c[23:16];
                rgb.green = c[15:8];
                rgb.blue  = c[7:0];
                expected_colors.push_back(rgb);
            end
            default: ;
        endcase
    endfunction

    // Offer one request after random idle cycles and hold it until accepted
    task automatic send_request(input logic [2:0] op, input logic [12:0] addr,
                                input logic [23:0] data, input logic [7:0] px,
                                input logic [7:0] py);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {3'b000, py, px, data, addr};
        do @(posedge aclk); while (!s_axis_tready);
        apply_request(op, addr, data, px, py);
    endtask

    // Drop valid and pause until every expected colour has come back
    task automatic wait_results_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (expected_colors.size() != 0) @(posedge aclk);
    endtask

    // Compare each accepted colour with the oldest expectation; drive tready
    always @(posedge aclk) begin
        pixel_rgb_t got;
        pixel_rgb_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata;
            if (expected_colors.size() == 0) begin
                $display("%0t: colour expected none actual %h", $realtime, got);
                error_count++;
            end else begin
                want = expected_colors.pop_front();
                if (got.red !== want.red) begin
                    $display("%0t: red expected %h actual %h", $realtime, want.red, got.red);
                    error_count++;
                end
                if (got.green !== want.green) begin
                    $display("%0t: green expected %h actual %h",
                             $realtime, want.green, got.green);
                    error_count++;
                end
                if (got.blue !== want.blue) begin
                    $display("%0t: blue expected %h actual %h",
                             $realtime, want.blue, got.blue);
                    error_count++;
                end
            end
        end
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else if (hold_cycles > 0) begin
            hold_cycles   <= hold_cycles - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Load the tile set, the name entries of the top band and the bottom row,
    // the palette and the sprites; sprites stay inside rows 16..55
    task automatic test_store_preload();
        int         i;
        int         t;
        int         r;
        int         b;
        logic [7:0] sheet_byte;
        for (t = 0; t < LOADED_TILES; t++) begin
            for (r = 0; r < 8; r++) begin
                for (b = 0; b < 4; b++) begin
                    sheet_byte[7:4] = $urandom_range(0, 1) ? 4'd0 : 4'($urandom_range(1, 15));
                    sheet_byte[3:0] = $urandom_range(0, 1) ? 4'd0 : 4'($urandom_range(1, 15));
                    send_request(tspc_pkg::OP_WRITE_SHEET,
                                 tspc_pkg::pat_addr(8'(TILE_BASE + t), 3'(2 * b), 3'(r)),
                                 {16'($urandom), sheet_byte}, 8'd0, 8'd0);
                end
            end
        end
        for (i = 0; i < NAME_DEPTH; i++) begin
            if (i / NAME_COLS < LOADED_TILE_ROWS || i / NAME_COLS == BG_TILE_ROWS - 1)
                send_request(tspc_pkg::OP_WRITE_NAME, 13'(i),
                             {16'($urandom), loaded_tile()}, 8'd0, 8'd0);
        end
        for (i = 0; i < PALETTE_DEPTH; i++)
            send_request(tspc_pkg::OP_WRITE_PALETTE, 13'(i), 24'($urandom), 8'd0, 8'd0);
        for (i = 0; i < SPRITES; i++)
            send_request(tspc_pkg::OP_WRITE_SPRITE, 13'(i),
                         {loaded_tile(), 8'($urandom_range(SPRITE_Y_MIN, SPRITE_Y_MAX)),
                          8'($urandom)},
                         8'd0, 8'd0);
        wait_results_drained();
    endtask

    // Corner cases: transparency, wrap, last sprite wins, rows off screen,
    // unknown codes and writes past the end of a store
    task automatic test_directed_cases();
        send_request(tspc_pkg::OP_WRITE_NAME, 13'd0, 24'h000021, 8'd0, 8'd0);
        send_request(tspc_pkg::OP_WRITE_SHEET, 13'd1028, 24'h00000A, 8'd0, 8'd0);
        send_request(tspc_pkg::OP_WRITE_PALETTE, 13'd0, 24'hFFFFFF, 8'd0, 8'd0);
        send_request(tspc_pkg::OP_WRITE_PALETTE, 13'd15, 24'h000000, 8'd0, 8'd0);
        send_request(tspc_pkg::OP_RENDER, 13'd0, 24'd0, 8'd0, 8'd0);
        send_request(tspc_pkg::OP_RENDER, 13'd0, 24'd0, 8'd1, 8'd0);
        send_request(OP_RESERVED_LO, 13'd0, 24'hFFFFFF, 8'd0, 8'd0);
        send_request(OP_RESERVED_MID, 13'h1FFF, 24'h00FF00, 8'd255, 8'd255);
        send_request(OP_RESERVED_HI, 13'd1, 24'h000000, 8'd0, 8'd0);
        send_request(tspc_pkg::OP_WRITE_PALETTE, 13'd16, 24'h123456, 8'd0, 8'd0);
        send_request(tspc_pkg::OP_WRITE_NAME, 13'(NAME_DEPTH), 24'h0000FF, 8'd0, 8'd0);
        send_request(tspc_pkg::OP_WRITE_SPRITE, 13'(SPRITES), 24'h000000, 8'd0, 8'd0);
        send_request(tspc_pkg::OP_WRITE_SPRITE, 13'h1FFF, 24'h000000, 8'd0, 8'd0);
        send_request(tspc_pkg::OP_RENDER, 13'd0, 24'd0, 8'd0, 8'd0);
        // sprite 0 at the origin, sprite 63 wrapped over both edges
        send_request(tspc_pkg::OP_WRITE_SPRITE, 13'd0, 24'h220000, 8'd0, 8'd0);
        send_request(tspc_pkg::OP_WRITE_SHEET, 13'd1032, 24'h0000C0, 8'd0, 8'd0);
        send_request(tspc_pkg::OP_WRITE_SPRITE, 13'(SPRITES - 1), 24'h21FAFC, 8'd0, 8'd0);
        send_request(tspc_pkg::OP_WRITE_SHEET, 13'd1798, 24'h000050, 8'd0, 8'd0);
        send_request(tspc_pkg::OP_RENDER, 13'd0, 24'd0, 8'd0, 8'd0);
        send_request(tspc_pkg::OP_WRITE_SHEET, 13'd1798, 24'h000000, 8'd0, 8'd0);
        send_request(tspc_pkg::OP_RENDER, 13'd0, 24'd0, 8'd0, 8'd0);
        send_request(tspc_pkg::OP_RENDER, 13'd0, 24'd0, 8'd255, 8'd1);
        // sprite straddling the bottom edge of the screen
        send_request(tspc_pkg::OP_WRITE_SPRITE, 13'd1, 24'h21DC64, 8'd0, 8'd0);
        send_request(tspc_pkg::OP_RENDER, 13'd0, 24'd0, 8'd100, 8'd223);
        send_request(tspc_pkg::OP_RENDER, 13'd0, 24'd0, 8'd100, 8'd224);
        send_request(tspc_pkg::OP_RENDER, 13'd0, 24'd0, 8'd255, 8'd255);
        send_request(tspc_pkg::OP_RENDER, 13'd0, 24'd0, 8'd255, 8'd223);
        wait_results_drained();
    endtask

    // Stall the output for a long stretch while renders keep coming
    task automatic test_output_backpressure();
        int i;
        @(posedge aclk);
        hold_cycles = 900;
        for (i = 0; i < 12; i++)
            send_request(tspc_pkg::OP_RENDER, 13'd0, 24'd0, 8'($urandom),
                         8'($urandom_range(0, LOADED_ROWS - 1)));
        wait_results_drained();
    endtask

    // Random mix: renders mostly aimed at sprites, writes, a little noise
    task automatic test_random_traffic(input int count);
        int          done;
        int          pick;
        logic [2:0]  op;
        logic [12:0] addr;
        logic [23:0] data;
        logic [7:0]  px;
        logic [7:0]  py;
        logic [23:0] spr;
        done = 0;
        while (done < count) begin
            pick = $urandom_range(0, 99);
            data = 24'($urandom);
            addr = 13'($urandom);
            px   = 8'($urandom);
            py   = 8'($urandom_range(0, LOADED_ROWS - 1));
            if (pick < 40) begin
                op   = tspc_pkg::OP_RENDER;
                pick = $urandom_range(0, 99);
                if (pick < 70) begin
                    spr = sprite_mirror[$urandom_range(0, SPRITES - 1)];
                    px  = spr[7:0] + 8'($urandom_range(0, 7));
                    py  = spr[15:8] + 8'($urandom_range(0, 7));
                    if (!row_loaded(py))
                        py = 8'($urandom_range(0, LOADED_ROWS - 1));
                end else if (pick < 95) begin
                    py = 8'($urandom_range(0, LOADED_ROWS - 1));
                end else begin
                    py = 8'($urandom_range(SCREEN_ROWS, 255));
                end
            end else if (pick < 55) begin
                op = tspc_pkg::OP_WRITE_SHEET;
                // aim half of the sheet writes at the tiles in use
                if ($urandom_range(0, 1) == 1)
                    addr = tspc_pkg::pat_addr(loaded_tile(), 3'($urandom), 3'($urandom));
            end else if (pick < 65) begin
                op = tspc_pkg::OP_WRITE_NAME;
                data[7:0] = loaded_tile();
                if ($urandom_range(0, 19) != 0) addr = 13'($urandom_range(0, NAME_DEPTH - 1));
            end else if (pick < 72) begin
                op = tspc_pkg::OP_WRITE_PALETTE;
                if ($urandom_range(0, 9) != 0) addr = 13'($urandom_range(0, PALETTE_DEPTH - 1));
            end else if (pick < 92) begin
                op = tspc_pkg::OP_WRITE_SPRITE;
                if ($urandom_range(0, 9) != 0) addr = 13'($urandom_range(0, SPRITES - 1));
                data[23:16] = loaded_tile();
                data[15:8]  = 8'($urandom_range(SPRITE_Y_MIN, SPRITE_Y_MAX));
                // cluster sprites so overlaps and priority get exercised
                if ($urandom_range(0, 1) == 1) begin
                    spr = sprite_mirror[$urandom_range(0, SPRITES - 1)];
                    data[7:0]  = spr[7:0] + 8'($urandom_range(0, 14)) - 8'd7;
                    data[15:8] = spr[15:8] + 8'($urandom_range(0, 14)) - 8'd7;
                    if (data[15:8] < SPRITE_Y_MIN || data[15:8] > SPRITE_Y_MAX)
                        data[15:8] = 8'($urandom_range(SPRITE_Y_MIN, SPRITE_Y_MAX));
                end
            end else begin
                op = 3'($urandom_range(OP_RESERVED_LO, OP_RESERVED_HI));
            end
            send_request(op, addr, data, px, py);
            // count only requests that render or change a store
            if (op == tspc_pkg::OP_RENDER || (op == tspc_pkg::OP_WRITE_SHEET)
                || (op == tspc_pkg::OP_WRITE_NAME && addr < NAME_DEPTH)
                || (op == tspc_pkg::OP_WRITE_PALETTE && addr < PALETTE_DEPTH)
                || (op == tspc_pkg::OP_WRITE_SPRITE && addr < SPRITES))
                done++;
        end
        wait_results_drained();
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_idle_pct = 8;
        recv_idle_pct = 59;
        test_store_preload();
        test_directed_cases();
        test_output_backpressure();
        test_random_traffic(115);

        send_idle_pct = 59;
        recv_idle_pct = 8;
        test_random_traffic(115);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_traffic(115);

        repeat (TAIL_CYCLES) @(posedge aclk);
        if (error_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // Guard against a hung handshake
    initial begin
        #10_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule

/* tile_sprite_pixel_compositor_top.f */
rtl/tspc_pkg.sv
rtl/tspc_ram.sv
rtl/tspc_ctrl.sv
rtl/tile_sprite_pixel_compositor_top.sv
tb/sv/tb_tile_sprite_pixel_compositor_top.sv
